### rtl/binary_to_decimal_ascii_assert.svh
// assertion macros for the binary to decimal ascii converter
// included by the top level, no other dependencies
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define B2DA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b2da implication check failed");

// next-cycle implication, checked while out of reset
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b2da next-cycle check failed");

`endif

### rtl/b2da_pkg.sv
// shared types, constants and the microcode rom of the binary to decimal converter
// no dependencies
`default_nettype none

package b2da_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int DATA_W         = 64;
    localparam int CHAR_W         = 6;
    localparam int TOTAL_W        = 5;
    localparam int M_DATA_W       = 16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // which handshake a step waits for
    typedef enum logic [1:0] {
        GATE_ALWAYS = 2'd0,
        GATE_IN     = 2'd1,
        GATE_OUT    = 2'd2
    } gate_t;

    // datapath operation of a step
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DABBLE = 2'd1,
        OP_TRIM   = 2'd2,
        OP_EMIT   = 2'd3
    } op_t;

    // jump condition, taken to the target step, else fall through
    typedef enum logic [1:0] {
        COND_NEVER       = 2'd0,
        COND_BITS_LEFT   = 2'd1,
        COND_LEAD_ZERO   = 2'd2,
        COND_DIGITS_LEFT = 2'd3
    } cond_t;

    typedef logic [1:0] step_t;

    localparam step_t STEP_LOAD   = 2'd0;
    localparam step_t STEP_DABBLE = 2'd1;
    localparam step_t STEP_TRIM   = 2'd2;
    localparam step_t STEP_EMIT   = 2'd3;
    localparam int    STEPS       = 4;

    typedef struct packed {
        gate_t gate;
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // the program: load, shift-add-3 per bit, drop leading zeros, emit digits
    localparam uword_t UCODE [STEPS] = '{
        '{gate: GATE_IN,     op: OP_LOAD,   cond: COND_NEVER,       target: STEP_LOAD},
        '{gate: GATE_ALWAYS, op: OP_DABBLE, cond: COND_BITS_LEFT,   target: STEP_DABBLE},
        '{gate: GATE_ALWAYS, op: OP_TRIM,   cond: COND_LEAD_ZERO,   target: STEP_TRIM},
        '{gate: GATE_OUT,    op: OP_EMIT,   cond: COND_DIGITS_LEFT, target: STEP_EMIT}
    };

endpackage

`default_nettype wire

### rtl/binary_to_decimal_ascii.sv
// binary to decimal ascii converter: one value in, its decimal digits out msd first
// steps: load, a one-bit-per-cycle shift-add-3 loop, a one-digit-per-cycle trim loop and a
//   one-digit-per-cycle emit loop that holds while the result channel stalls; a new value is
//   taken only after the last digit of the previous one has been emitted
// reset: synchronous active-low aresetn clears the step counter and the output valid
// uses b2da_pkg and binary_to_decimal_ascii_assert.svh
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [b2da_pkg::DATA_W-1:0]   s_tdata,   // [63:0] value
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [b2da_pkg::M_DATA_W-1:0]      m_tdata,   // [5:0] digit_char, [10:6] digit_total
    output logic                               m_tlast    // last_digit
);

    // decimal digits of 2^VALUE_BITS - 1, log10(2) ~ 0.30103
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int BIT_CW = $clog2(VALUE_BITS + 1);
    localparam int DIG_CW = $clog2(DIGITS + 1);
    localparam int TW     = b2da_pkg::TOTAL_W;
    localparam int CW     = b2da_pkg::CHAR_W;

    // sequencer state
    b2da_pkg::step_t  pc_reg, pc_next;
    b2da_pkg::uword_t uw;

    // datapath registers
    logic [VALUE_BITS-1:0] val_reg, val_next;       // binary value being shifted out
    logic [BCD_W-1:0]      bcd_reg, bcd_next;       // packed bcd digits, msd at top
    logic [BIT_CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]     total_reg, total_next;   // digit count after trimming
    logic [DIG_CW-1:0]     rem_reg, rem_next;       // digits still to emit

    // output register, parts the sequencer from the result channel
    logic                  out_valid_reg, out_valid_next;
    logic [CW-1:0]         out_char_reg, out_char_next;
    logic [TW-1:0]         out_total_reg, out_total_next;
    logic                  out_last_reg, out_last_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  lead_zero;
    logic                  slot_free;
    logic                  gate_ok;
    logic                  cond_ok;

    // current control word straight from the rom
    assign uw = b2da_pkg::UCODE[pc_reg];

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    // a leading zero may be dropped while more than one digit remains
    assign lead_zero = (top_digit == 4'd0) && (total_reg != DIG_CW'(1));
    // result slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || m_tready;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < DIGITS; i++) begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    // gate select: which handshake lets the step proceed
    always_comb begin
        unique case (uw.gate)
            b2da_pkg::GATE_ALWAYS: gate_ok = 1'b1;
            b2da_pkg::GATE_IN:     gate_ok = s_tvalid;
            b2da_pkg::GATE_OUT:    gate_ok = slot_free;
            default:               gate_ok = 1'b0;
        endcase
    end

    // jump condition select
    always_comb begin
        unique case (uw.cond)
            b2da_pkg::COND_NEVER:       cond_ok = 1'b0;
            b2da_pkg::COND_BITS_LEFT:   cond_ok = (bit_cnt_reg != BIT_CW'(1));
            b2da_pkg::COND_LEAD_ZERO:   cond_ok = lead_zero;
            b2da_pkg::COND_DIGITS_LEFT: cond_ok = (rem_reg != DIG_CW'(1));
            default:                    cond_ok = 1'b0;
        endcase
    end

    // datapath and step counter next values
    always_comb begin
        pc_next        = pc_reg;
        val_next       = val_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        if (gate_ok) begin
            unique case (uw.op)
                b2da_pkg::OP_LOAD: begin
                    val_next     = s_tdata[VALUE_BITS-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_BITS);
                    total_next   = DIG_CW'(DIGITS);
                    rem_next     = DIG_CW'(DIGITS);
                end
                b2da_pkg::OP_DABBLE: begin
                    // shift the next binary msb into the corrected bcd word
                    bcd_next     = {bcd_adj[BCD_W-2:0], val_reg[VALUE_BITS-1]};
                    val_next     = {val_reg[VALUE_BITS-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
                end
                b2da_pkg::OP_TRIM: begin
                    if (lead_zero) begin
                        bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                        total_next = total_reg - DIG_CW'(1);
                        rem_next   = rem_reg - DIG_CW'(1);
                    end
                end
                b2da_pkg::OP_EMIT: begin
                    out_valid_next = 1'b1;
                    out_char_next  = b2da_pkg::ASCII_ZERO + CW'(top_digit);
                    out_total_next = TW'(total_reg);
                    out_last_next  = (rem_reg == DIG_CW'(1));
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next       = rem_reg - DIG_CW'(1);
                end
                default: begin
                    bcd_next = bcd_reg;
                end
            endcase
            // taken jump goes to the target, else fall through (emit wraps to load)
            pc_next = cond_ok ? uw.target : pc_reg + b2da_pkg::step_t'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= b2da_pkg::STEP_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        bcd_reg       <= bcd_next;
        bit_cnt_reg   <= bit_cnt_next;
        total_reg     <= total_next;
        rem_reg       <= rem_next;
        out_char_reg  <= out_char_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    // input transaction only on the load step
    assign s_tready = (uw.gate == b2da_pkg::GATE_IN);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(b2da_pkg::M_DATA_W - CW - TW){1'b0}}, out_total_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

    // checks on the sequencer and the bcd datapath
`include "binary_to_decimal_ascii_assert.svh"

    // every bcd digit handed to the output is a decimal digit
    `B2DA_ASSERT_IMPL(a_emit_digit_range, aclk, aresetn,
        (uw.op == b2da_pkg::OP_EMIT), (top_digit <= 4'd9))

    // the first digit of a multi-digit run is never a zero
    `B2DA_ASSERT_IMPL(a_no_leading_zero, aclk, aresetn,
        (uw.op == b2da_pkg::OP_EMIT) && (rem_reg == total_reg) && (total_reg != DIG_CW'(1)),
        (top_digit != 4'd0))

    // the shift loop never runs with an exhausted bit count
    `B2DA_ASSERT_IMPL(a_dabble_count, aclk, aresetn,
        (uw.op == b2da_pkg::OP_DABBLE), (bit_cnt_reg != '0))

    // a final digit sends the sequencer back to the load step
    `B2DA_ASSERT_NEXT(a_last_returns, aclk, aresetn,
        (uw.op == b2da_pkg::OP_EMIT) && slot_free && (rem_reg == DIG_CW'(1)),
        (pc_reg == b2da_pkg::STEP_LOAD))

endmodule

`default_nettype wire

### tb/binary_to_decimal_ascii_test.sv
// self-checking bench for binary_to_decimal_ascii: streams 64-bit values in and checks
// every decimal digit transaction against digits worked out here, msd first
// depends on b2da_pkg and the binary_to_decimal_ascii top level
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

    localparam int          VALUE_BITS   = b2da_pkg::VALUE_BITS_DEF;
    localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int          DECIMAL_BASE = 10;
    localparam int          MAX_DIGITS   = 20;
    localparam int          RANDOM_ITEMS = 448;
    localparam int          CALM_TAIL    = 40;    // final items sent with no idling
    localparam int          SETTLE_EVERY = 150;   // sender drains the block this often

    // one expected digit transaction
    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0]  digit_char;
        logic [b2da_pkg::TOTAL_W-1:0] digit_total;
        logic                         last_digit;
    } digit_t;

    // one value waiting for the driver
    typedef struct {
        logic [63:0] value;
        bit          settle;   // hold off until every digit so far has come out
    } pending_value_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [b2da_pkg::DATA_W-1:0]   s_tdata  = '0;     // [63:0] value
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [b2da_pkg::M_DATA_W-1:0] m_tdata;           // [5:0] digit_char, [10:6] digit_total
    logic                          m_tlast;           // last_digit

    pending_value_t values_to_send [$];
    digit_t         digits_due [$];
    int             mismatches  = 0;
    int             values_sent = 0;
    int             send_gap    = 0;
    int             recv_gap    = 0;
    int             stall_pct   = 25;      // chance of a new idle burst, shared by both sides
    bit             calm_phase  = 1'b0;

    binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // split a value into decimal digits and queue them msd first
    function automatic void queue_decimal_digits(input logic [63:0] value);
        logic [3:0]  lsd_first [MAX_DIGITS];
        logic [63:0] rest;
        int          count;
        digit_t      d;
        rest  = value & VALUE_MASK;
        count = 0;
        // zero still yields one digit
        do begin
            lsd_first[count] = 4'(rest % DECIMAL_BASE);
            rest             = rest / DECIMAL_BASE;
            count++;
        end while (rest != 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            d.digit_char  = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(lsd_first[k]);
            d.digit_total = b2da_pkg::TOTAL_W'(count);
            d.last_digit  = (k == 0);
            digits_due.push_back(d);
        end
    endfunction

    function automatic void add_value(input logic [63:0] value, input bit settle);
        pending_value_t p;
        p.value  = value;
        p.settle = settle;
        values_to_send.push_back(p);
    endfunction

    // driver: presents queued values, idles in bursts, drains the block on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                queue_decimal_digits(s_tdata);
                values_sent++;
                // new idle mix every few dozen values, sometimes none at all
                if (values_sent % 37 == 0)
                    stall_pct = 15 * $urandom_range(0, 3);
            end
            calm_phase = (values_to_send.size() < CALM_TAIL);
            // bus is free once the last transaction went through or nothing was offered
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && !calm_phase && $urandom_range(1, 100) <= stall_pct)
                    send_gap = $urandom_range(1, 14);
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (values_to_send.size() != 0 &&
                             (!values_to_send[0].settle || digits_due.size() == 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= values_to_send[0].value;
                    void'(values_to_send.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stalls the result side in bursts and checks each digit transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digits_due.size() == 0) begin
                    $error("digit transaction with none expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    if (m_tdata[b2da_pkg::CHAR_W-1:0] !== digits_due[0].digit_char) begin
                        $error("digit_char: expected %0d, actual %0d",
                               digits_due[0].digit_char, m_tdata[b2da_pkg::CHAR_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[b2da_pkg::CHAR_W +: b2da_pkg::TOTAL_W] !==
                        digits_due[0].digit_total) begin
                        $error("digit_total: expected %0d, actual %0d",
                               digits_due[0].digit_total,
                               m_tdata[b2da_pkg::CHAR_W +: b2da_pkg::TOTAL_W]);
                        mismatches++;
                    end
                    if (m_tlast !== digits_due[0].last_digit) begin
                        $error("last_digit: expected %0b, actual %0b",
                               digits_due[0].last_digit, m_tlast);
                        mismatches++;
                    end
                    void'(digits_due.pop_front());
                end
            end
            if (recv_gap == 0 && !calm_phase && $urandom_range(1, 100) <= stall_pct)
                recv_gap = $urandom_range(1, 14);
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus, then wait for the block to drain and report
    initial begin
        logic [63:0] pow10;
        int          bits;
        int          n;
        // directed: zero, single digits, decade edges, full width and bit patterns
        add_value(64'd0, 1'b0);
        add_value(64'd1, 1'b0);
        add_value(64'd9, 1'b0);
        add_value(64'd10, 1'b0);
        add_value(64'd99, 1'b0);
        add_value(64'd100, 1'b0);
        add_value(64'd1000000000, 1'b0);
        add_value(64'd4294967295, 1'b0);
        add_value(64'd4294967296, 1'b0);
        add_value(64'd999999999999999999, 1'b0);
        add_value(64'd9999999999999999999, 1'b0);
        add_value(64'd10000000000000000000, 1'b0);
        add_value(64'd12345678901234567890, 1'b0);
        add_value(64'h8000_0000_0000_0000, 1'b0);
        add_value(64'h7fff_ffff_ffff_ffff, 1'b0);
        add_value(64'h5555_5555_5555_5555, 1'b0);
        add_value(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        add_value(64'hffff_ffff_ffff_ffff, 1'b0);
        add_value(64'd0, 1'b1);    // after a drain, smallest right after largest
        add_value(64'hffff_ffff_ffff_ffff, 1'b0);
        add_value(64'd7, 1'b0);
        // random: spread over all lengths, some right at decade boundaries
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                n     = $urandom_range(1, 19);
                pow10 = 64'd1;
                repeat (n) pow10 = pow10 * DECIMAL_BASE;
                add_value(pow10 + 64'($urandom_range(0, 2)) - 64'd1, (i % SETTLE_EVERY) == 0);
            end else begin
                bits = $urandom_range(1, 64);
                add_value({$urandom, $urandom} >> (64 - bits), (i % SETTLE_EVERY) == 0);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (values_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (digits_due.size() != 0) @(posedge aclk);
        // room for any stray digit after the last expected one
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop, several times the slowest correct run
    initial begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
